// ----- rtl/core/wpsd_pkg.sv -----
`default_nettype none

package wpsd_pkg;

  typedef enum logic [4:0] {
    PH_RIFF = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_BODY = 5'b00100,
    PH_PAD  = 5'b01000,
    PH_HALT = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    CK_OTHER = 2'd0,
    CK_FMT   = 2'd1,
    CK_DATA  = 2'd2
  } chunk_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_END    = 2'd1,
    KIND_ERR    = 2'd2
  } kind_t;

  localparam logic [2:0] ERR_RIFF  = 3'd0;
  localparam logic [2:0] ERR_WAVE  = 3'd1;
  localparam logic [2:0] ERR_PCM   = 3'd2;
  localparam logic [2:0] ERR_BITS  = 3'd3;
  localparam logic [2:0] ERR_NOFMT = 3'd4;

  localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
  localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
  localparam logic [31:0] MAGIC_FMT  = 32'h2074_6D66;
  localparam logic [31:0] MAGIC_DATA = 32'h6174_6164;
  localparam logic [15:0] PCM_CODE   = 16'h0001;
  localparam logic [15:0] BITS_NARROW = 16'd8;
  localparam logic [15:0] BITS_WIDE   = 16'd16;
  localparam logic [7:0]  BIAS8      = 8'd128;

  localparam logic [4:0] FC_RIFF_MAGIC = 5'd3;
  localparam logic [4:0] FC_WAVE_MAGIC = 5'd11;
  localparam logic [4:0] FC_HDR_ID     = 5'd3;
  localparam logic [4:0] FC_HDR_SIZE   = 5'd7;
  localparam logic [4:0] FC_FMT_CODE   = 5'd1;
  localparam logic [4:0] FC_FMT_CHAN   = 5'd3;
  localparam logic [4:0] FC_FMT_RATE   = 5'd7;
  localparam logic [4:0] FC_FMT_BITS   = 5'd15;
  localparam logic [4:0] FC_FMT_LIMIT  = 5'd16;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  sample;
    logic [2:0]  error_code;
    logic [31:0] sample_rate;
    logic [15:0] channels;
    logic        last;
  } res_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  fc;
    logic [31:0] aw;
    chunk_t      ck;
    logic [31:0] rem;
    logic        odd;
    logic        fmt_seen;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic        wide;
    logic [31:0] rate;
    logic [16:0] fo;
    logic [16:0] fb;
  } pst_t;

  localparam pst_t PST_RESET = '{
    phase:    PH_RIFF,
    fc:       5'd0,
    aw:       32'd0,
    ck:       CK_OTHER,
    rem:      32'd0,
    odd:      1'b0,
    fmt_seen: 1'b0,
    fmt_code: 16'd0,
    chans:    16'd1,
    wide:     1'b0,
    rate:     32'd0,
    fo:       17'd0,
    fb:       17'd1
  };

endpackage

`default_nettype wire

// ----- rtl/core/wav_pcm_stream_deframer_top.sv -----
// RIFF/WAVE PCM deframer: one file byte per input request, audio results out.
// Input channel: in_valid/in_stall with in_byte_value, in_start_of_file
// (restarts the parser on that byte) and in_end_of_file (final byte; an
// error is reported if no valid fmt chunk was seen).
// Result channel: out_valid/out_stall with out_kind (sample, end of data
// chunk, error), out_sample, out_error_code, out_sample_rate, out_channels
// and out_last, which marks the last result caused by one byte.
// A byte passes the input register, then the two-entry result queue.
// Throughput: one byte per cycle while the queue has room for its results;
// a byte with no result never waits on the output side. The result port
// delivers one result per cycle while out_stall is low; a byte that ends
// a data chunk with a sample yields two results, a sample and an end.
// Reset: synchronous, rst_n low; the parser waits for the RIFF header and
// the result queue is emptied.
// Stall: while out_stall is high the head result holds; the queue keeps
// taking bytes while it has room for their results, then in_stall rises.
`default_nettype none

module wav_pcm_stream_deframer_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_byte_value,
  input  wire logic              in_start_of_file,
  input  wire logic              in_end_of_file,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_kind,
  output logic signed [7:0]      out_sample,
  output logic [2:0]             out_error_code,
  output logic [31:0]            out_sample_rate,
  output logic [15:0]            out_channels,
  output logic                   out_last
);

  logic            in_vld_r;
  wpsd_pkg::item_t item_r;
  logic            adv;
  logic            pop;
  logic [1:0]      nres;
  logic [1:0]      room;
  wpsd_pkg::res_t  res0;
  wpsd_pkg::res_t  res1;
  wpsd_pkg::res_t  head;

  assign adv = in_vld_r && (nres <= room);
  assign in_stall = in_vld_r && !adv;
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= '{byte_value: in_byte_value, start_of_file: in_start_of_file,
                  end_of_file: in_end_of_file};
    end
  end

  wpsd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item_r),
    .adv   (adv),
    .res0  (res0),
    .res1  (res1),
    .nres  (nres)
  );

  wpsd_res_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (adv),
    .nres     (nres),
    .res0     (res0),
    .res1     (res1),
    .pop      (pop),
    .room     (room),
    .head_vld (out_valid),
    .head     (head)
  );

  assign out_kind        = head.kind;
  assign out_sample      = $signed(head.sample);
  assign out_error_code  = head.error_code;
  assign out_sample_rate = head.sample_rate;
  assign out_channels    = head.channels;
  assign out_last        = head.last;

endmodule

`default_nettype wire

// ----- rtl/core/wpsd_parser.sv -----
`default_nettype none

module wpsd_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire wpsd_pkg::item_t item,
  input  wire logic            adv,
  output wpsd_pkg::res_t       res0,
  output wpsd_pkg::res_t       res1,
  output logic [1:0]           nres
);

  wpsd_pkg::pst_t st_r;
  wpsd_pkg::pst_t st_nxt;

  logic        e_smp;
  logic        e_end;
  logic        e_err;
  logic [7:0]  smp_val;
  logic [2:0]  err_val;

  always_comb begin
    wpsd_pkg::pst_t cur;
    wpsd_pkg::pst_t s;
    logic [15:0] hi;
    logic [16:0] fo_inc;
    logic [7:0]  b;
    cur = item.start_of_file ? wpsd_pkg::PST_RESET : st_r;
    s = cur;
    b = item.byte_value;
    e_smp = 1'b0;
    e_end = 1'b0;
    e_err = 1'b0;
    smp_val = 8'd0;
    err_val = wpsd_pkg::ERR_RIFF;
    fo_inc = cur.fo + 17'd1;
    if (cur.phase != wpsd_pkg::PH_HALT) begin
      s.aw = {b, cur.aw[31:8]};
    end
    hi = s.aw[31:16];
    case (cur.phase)
      wpsd_pkg::PH_RIFF: begin
        if (cur.fc == wpsd_pkg::FC_RIFF_MAGIC && s.aw != wpsd_pkg::MAGIC_RIFF) begin
          e_err = 1'b1;
          err_val = wpsd_pkg::ERR_RIFF;
          s.phase = wpsd_pkg::PH_HALT;
        end else if (cur.fc == wpsd_pkg::FC_WAVE_MAGIC) begin
          if (s.aw != wpsd_pkg::MAGIC_WAVE) begin
            e_err = 1'b1;
            err_val = wpsd_pkg::ERR_WAVE;
            s.phase = wpsd_pkg::PH_HALT;
          end else begin
            s.phase = wpsd_pkg::PH_HDR;
            s.fc = 5'd0;
          end
        end else begin
          s.fc = cur.fc + 5'd1;
        end
      end
      wpsd_pkg::PH_HDR: begin
        if (cur.fc == wpsd_pkg::FC_HDR_ID) begin
          if (s.aw == wpsd_pkg::MAGIC_FMT) begin
            s.ck = wpsd_pkg::CK_FMT;
          end else if (s.aw == wpsd_pkg::MAGIC_DATA) begin
            s.ck = wpsd_pkg::CK_DATA;
          end else begin
            s.ck = wpsd_pkg::CK_OTHER;
          end
          s.fc = cur.fc + 5'd1;
        end else if (cur.fc == wpsd_pkg::FC_HDR_SIZE) begin
          s.rem = s.aw;
          s.odd = s.aw[0];
          s.fc = 5'd0;
          s.phase = wpsd_pkg::PH_BODY;
          if (cur.ck == wpsd_pkg::CK_FMT) begin
            s.fmt_seen = 1'b0;
            s.fmt_code = 16'd0;
            s.chans = 16'd1;
            s.wide = 1'b0;
            s.rate = 32'd0;
            s.fb = 17'd1;
          end else if (cur.ck == wpsd_pkg::CK_DATA) begin
            s.fo = 17'd0;
            if (!cur.fmt_seen) begin
              e_err = 1'b1;
              err_val = wpsd_pkg::ERR_NOFMT;
              s.phase = wpsd_pkg::PH_HALT;
            end
          end
          if (s.phase == wpsd_pkg::PH_BODY && s.rem == 32'd0) begin
            e_end = (cur.ck == wpsd_pkg::CK_DATA);
            s.phase = s.odd ? wpsd_pkg::PH_PAD : wpsd_pkg::PH_HDR;
            s.fc = 5'd0;
          end
        end else begin
          s.fc = cur.fc + 5'd1;
        end
      end
      wpsd_pkg::PH_BODY: begin
        s.rem = cur.rem - 32'd1;
        if (cur.ck == wpsd_pkg::CK_FMT) begin
          if (cur.fc == wpsd_pkg::FC_FMT_CODE) begin
            s.fmt_code = hi;
            if (hi != wpsd_pkg::PCM_CODE) begin
              e_err = 1'b1;
              err_val = wpsd_pkg::ERR_PCM;
              s.phase = wpsd_pkg::PH_HALT;
            end
          end else if (cur.fc == wpsd_pkg::FC_FMT_CHAN) begin
            s.chans = (hi != 16'd0) ? hi : 16'd1;
          end else if (cur.fc == wpsd_pkg::FC_FMT_RATE) begin
            s.rate = s.aw;
          end else if (cur.fc == wpsd_pkg::FC_FMT_BITS) begin
            if (hi == wpsd_pkg::BITS_NARROW || hi == wpsd_pkg::BITS_WIDE) begin
              s.wide = (hi == wpsd_pkg::BITS_WIDE);
              s.fb = s.wide ? {cur.chans, 1'b0} : {1'b0, cur.chans};
              s.fmt_seen = 1'b1;
            end else begin
              e_err = 1'b1;
              err_val = wpsd_pkg::ERR_BITS;
              s.phase = wpsd_pkg::PH_HALT;
            end
          end
          if (cur.fc < wpsd_pkg::FC_FMT_LIMIT) begin
            s.fc = cur.fc + 5'd1;
          end
        end else if (cur.ck == wpsd_pkg::CK_DATA) begin
          if (cur.fo == {16'd0, cur.wide}) begin
            e_smp = 1'b1;
            smp_val = cur.wide ? b : (b - wpsd_pkg::BIAS8);
          end
          s.fo = (fo_inc >= cur.fb) ? 17'd0 : fo_inc;
        end
        if (s.phase == wpsd_pkg::PH_BODY && s.rem == 32'd0) begin
          e_end = (cur.ck == wpsd_pkg::CK_DATA);
          s.phase = cur.odd ? wpsd_pkg::PH_PAD : wpsd_pkg::PH_HDR;
          s.fc = 5'd0;
        end
      end
      wpsd_pkg::PH_PAD: begin
        s.phase = wpsd_pkg::PH_HDR;
        s.fc = 5'd0;
      end
      default: begin
      end
    endcase
    if (item.end_of_file && s.phase != wpsd_pkg::PH_HALT) begin
      if (!s.fmt_seen) begin
        e_err = 1'b1;
        err_val = wpsd_pkg::ERR_NOFMT;
      end
      s.phase = wpsd_pkg::PH_HALT;
    end
    st_nxt = s;
  end

  always_comb begin
    wpsd_pkg::res_t base;
    base = '{kind: wpsd_pkg::KIND_SAMPLE, sample: 8'd0, error_code: wpsd_pkg::ERR_RIFF,
             sample_rate: st_nxt.rate, channels: st_nxt.chans, last: 1'b0};
    res0 = base;
    res1 = base;
    res1.kind = wpsd_pkg::KIND_END;
    res1.last = 1'b1;
    nres = {1'b0, e_smp} + {1'b0, e_end} + {1'b0, e_err};
    if (e_smp) begin
      res0.sample = smp_val;
      res0.last = !e_end;
    end else if (e_end) begin
      res0.kind = wpsd_pkg::KIND_END;
      res0.last = 1'b1;
    end else begin
      res0.kind = wpsd_pkg::KIND_ERR;
      res0.error_code = err_val;
      res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= wpsd_pkg::PST_RESET;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    adv && nres != 2'd0 && res0.kind == wpsd_pkg::KIND_ERR |=> st_r.phase == wpsd_pkg::PH_HALT)
    else $error("error result without halt");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    adv && nres == 2'd2 |-> res0.kind == wpsd_pkg::KIND_SAMPLE && !res0.last)
    else $error("bad result pair");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && st_r.phase == wpsd_pkg::PH_HALT && !item.start_of_file |-> nres == 2'd0)
    else $error("result while halted");

endmodule

`default_nettype wire

// ----- rtl/core/wpsd_res_queue.sv -----
`default_nettype none

module wpsd_res_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire logic [1:0]     nres,
  input  wire wpsd_pkg::res_t res0,
  input  wire wpsd_pkg::res_t res1,
  input  wire logic           pop,
  output logic [1:0]          room,
  output logic                head_vld,
  output wpsd_pkg::res_t      head
);

  wpsd_pkg::res_t slot0_r;
  wpsd_pkg::res_t slot1_r;
  wpsd_pkg::res_t slot0_nxt;
  wpsd_pkg::res_t slot1_nxt;
  logic [1:0]     cnt_r;
  logic [1:0]     cnt_nxt;

  assign room = 2'd2 - cnt_r;
  assign head_vld = (cnt_r != 2'd0);
  assign head = slot0_r;

  always_comb begin
    logic [1:0] c;
    logic [1:0] n;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    c = cnt_r;
    n = push ? nres : 2'd0;
    if (pop) begin
      slot0_nxt = slot1_r;
      c = c - 2'd1;
    end
    if (n != 2'd0) begin
      if (c == 2'd0) begin
        slot0_nxt = res0;
        if (n == 2'd2) begin
          slot1_nxt = res1;
        end
      end else begin
        slot1_nxt = res0;
      end
    end
    cnt_nxt = c + n;
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> nres <= room)
    else $error("result queue overflow");

endmodule

`default_nettype wire

// ----- tb/wav_pcm_deframer_checker.sv -----
`timescale 1ns / 100ps

module wav_pcm_deframer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_start_of_file,
  input  logic        in_end_of_file,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_sample,
  input  logic [2:0]  out_error_code,
  input  logic [31:0] out_sample_rate,
  input  logic [15:0] out_channels,
  input  logic        out_last,
  output int          mismatches,
  output int          awaited
);
  import wpsd_pkg::*;

  localparam logic [2:0] NO_ERROR = 3'd0;

  phase_t      phase;
  logic [4:0]  field_idx;
  logic [31:0] shift_word;
  chunk_t      chunk;
  logic [31:0] chunk_left;
  logic        chunk_pad;
  logic        format_valid;
  logic [15:0] chan_count;
  logic        sixteen_bit;
  logic [31:0] rate_reg;
  logic [16:0] frame_pos;
  logic [16:0] frame_len;

  res_t predicted_events[$];
  res_t byte_events[$];

  task automatic clear_parser();
    phase        = PH_RIFF;
    field_idx    = '0;
    shift_word   = '0;
    chunk        = CK_OTHER;
    chunk_left   = '0;
    chunk_pad    = 1'b0;
    format_valid = 1'b0;
    chan_count   = 16'd1;
    sixteen_bit  = 1'b0;
    rate_reg     = '0;
    frame_pos    = '0;
    frame_len    = 17'd1;
  endtask

  task automatic add_event(input kind_t k, input logic [7:0] smp, input logic [2:0] code);
    res_t r;
    r.kind        = k;
    r.sample      = smp;
    r.error_code  = code;
    r.sample_rate = rate_reg;
    r.channels    = chan_count;
    r.last        = 1'b0;
    byte_events.push_back(r);
  endtask

  task automatic abort_file(input logic [2:0] code);
    phase = PH_HALT;
    add_event(KIND_ERR, 8'd0, code);
  endtask

  task automatic close_chunk();
    phase     = chunk_pad ? PH_PAD : PH_HDR;
    field_idx = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic sof, input logic eof);
    logic [15:0] upper;
    res_t        tail;
    byte_events.delete();
    if (sof)
      clear_parser();
    if (phase != PH_HALT)
      shift_word = {b, shift_word[31:8]};
    upper = shift_word[31:16];
    case (phase)
      PH_RIFF: begin
        if (field_idx == FC_RIFF_MAGIC && shift_word != MAGIC_RIFF) begin
          abort_file(ERR_RIFF);
        end else if (field_idx == FC_WAVE_MAGIC) begin
          if (shift_word != MAGIC_WAVE) begin
            abort_file(ERR_WAVE);
          end else begin
            phase     = PH_HDR;
            field_idx = '0;
          end
        end else begin
          field_idx++;
        end
      end
      PH_HDR: begin
        if (field_idx == FC_HDR_ID) begin
          if (shift_word == MAGIC_FMT)
            chunk = CK_FMT;
          else if (shift_word == MAGIC_DATA)
            chunk = CK_DATA;
          else
            chunk = CK_OTHER;
          field_idx++;
        end else if (field_idx == FC_HDR_SIZE) begin
          chunk_left = shift_word;
          chunk_pad  = shift_word[0];
          field_idx  = '0;
          phase      = PH_BODY;
          if (chunk == CK_FMT) begin
            format_valid = 1'b0;
            chan_count   = 16'd1;
            sixteen_bit  = 1'b0;
            rate_reg     = '0;
            frame_len    = 17'd1;
          end else if (chunk == CK_DATA) begin
            frame_pos = '0;
            if (!format_valid)
              abort_file(ERR_NOFMT);
          end
          if (phase == PH_BODY && chunk_left == 0) begin
            if (chunk == CK_DATA)
              add_event(KIND_END, 8'd0, NO_ERROR);
            close_chunk();
          end
        end else begin
          field_idx++;
        end
      end
      PH_BODY: begin
        chunk_left--;
        if (chunk == CK_FMT) begin
          case (field_idx)
            FC_FMT_CODE: begin
              if (upper != PCM_CODE)
                abort_file(ERR_PCM);
            end
            FC_FMT_CHAN: chan_count = (upper != 16'd0) ? upper : 16'd1;
            FC_FMT_RATE: rate_reg = shift_word;
            FC_FMT_BITS: begin
              if (upper == BITS_NARROW || upper == BITS_WIDE) begin
                sixteen_bit  = (upper == BITS_WIDE);
                frame_len    = {1'b0, chan_count} << sixteen_bit;
                format_valid = 1'b1;
              end else begin
                abort_file(ERR_BITS);
              end
            end
            default: ;
          endcase
          if (field_idx < FC_FMT_LIMIT)
            field_idx++;
        end else if (chunk == CK_DATA) begin
          if (frame_pos == {16'd0, sixteen_bit})
            add_event(KIND_SAMPLE, sixteen_bit ? b : b - BIAS8, NO_ERROR);
          frame_pos++;
          if (frame_pos >= frame_len)
            frame_pos = '0;
        end
        if (phase == PH_BODY && chunk_left == 0) begin
          if (chunk == CK_DATA)
            add_event(KIND_END, 8'd0, NO_ERROR);
          close_chunk();
        end
      end
      PH_PAD: begin
        phase     = PH_HDR;
        field_idx = '0;
      end
      default: ;
    endcase
    if (eof && phase != PH_HALT) begin
      if (!format_valid)
        abort_file(ERR_NOFMT);
      phase = PH_HALT;
    end
    if (byte_events.size() > 0) begin
      tail = byte_events.pop_back();
      tail.last = 1'b1;
      byte_events.push_back(tail);
    end
    foreach (byte_events[i])
      predicted_events.push_back(byte_events[i]);
  endtask

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    int   bad;
    if (!rst_n) begin
      clear_parser();
      predicted_events.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_events.size() == 0) begin
          $display("%0t: result expected none actual kind %0d sample %0h error %0d",
                   $time, out_kind, out_sample, out_error_code);
          mismatches++;
        end else begin
          want = predicted_events.pop_front();
          bad = field_differs("kind", 32'(want.kind), 32'(out_kind))
              + field_differs("sample", 32'(want.sample), 32'(out_sample))
              + field_differs("error_code", 32'(want.error_code), 32'(out_error_code))
              + field_differs("sample_rate", want.sample_rate, out_sample_rate)
              + field_differs("channels", 32'(want.channels), 32'(out_channels))
              + field_differs("last", 32'(want.last), 32'(out_last));
          mismatches += bad;
        end
      end
      if (in_valid && !in_stall)
        deframe_byte(in_byte_value, in_start_of_file, in_end_of_file);
    end
    awaited = predicted_events.size();
  end

endmodule

// ----- tb/wav_pcm_stream_deframer_top_test.sv -----
`timescale 1ns / 100ps

module wav_pcm_stream_deframer_top_test;
  import wpsd_pkg::*;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte_value;
  logic        in_start_of_file;
  logic        in_end_of_file;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_sample;
  logic [2:0]  out_error_code;
  logic [31:0] out_sample_rate;
  logic [15:0] out_channels;
  logic        out_last;

  int mismatches;
  int awaited;
  int burst_left = 0;
  int bytes_sent = 0;
  int stall_left = 0;
  int stall_tick = 0;
  stall_style_t stall_style = STALL_NONE;
  logic [7:0] wav_bytes[$];

  wav_pcm_stream_deframer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_value    (in_byte_value),
    .in_start_of_file (in_start_of_file),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_sample       (out_sample),
    .out_error_code   (out_error_code),
    .out_sample_rate  (out_sample_rate),
    .out_channels     (out_channels),
    .out_last         (out_last)
  );

  wav_pcm_deframer_checker result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_value    (in_byte_value),
    .in_start_of_file (in_start_of_file),
    .in_end_of_file   (in_end_of_file),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_sample       (out_sample),
    .out_error_code   (out_error_code),
    .out_sample_rate  (out_sample_rate),
    .out_channels     (out_channels),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .awaited          (awaited)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_left  = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_style)
      STALL_NONE:  out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(0, 9) < 3);
      STALL_HEAVY: out_stall = ($urandom_range(0, 9) < 7);
      default:     out_stall = ((stall_tick % 5) >= 3);
    endcase
  end

  task automatic send_byte(input logic [7:0] b, input logic sof, input logic eof);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid         = 1'b1;
    in_byte_value    = b;
    in_start_of_file = sof;
    in_end_of_file   = eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic put_word(input logic [31:0] value, input int count);
    for (int i = 0; i < count; i++)
      wav_bytes.push_back(value[8 * i +: 8]);
  endtask

  task automatic put_chunk(input logic [31:0] id, input int len);
    put_word(id, 4);
    put_word(len, 4);
    for (int i = 0; i < len + (len % 2); i++)
      wav_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_header(input logic [31:0] riff_id, input logic [31:0] wave_id);
    put_word(riff_id, 4);
    put_word($urandom, 4);
    put_word(wave_id, 4);
  endtask

  task automatic put_fmt(input logic [15:0] code, input logic [15:0] chans,
                         input logic [31:0] rate, input logic [15:0] bits, input int len);
    put_word(MAGIC_FMT, 4);
    put_word(len, 4);
    put_word(32'(code), 2);
    put_word(32'(chans), 2);
    put_word(rate, 4);
    put_word($urandom, 4);
    put_word($urandom, 2);
    put_word(32'(bits), 2);
    for (int i = len; i < 16; i++)
      wav_bytes.delete(wav_bytes.size() - 1);
    for (int i = 16; i < len; i++)
      wav_bytes.push_back(8'($urandom_range(0, 255)));
    if (len % 2)
      wav_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_random_fmt();
    logic [15:0] bits;
    logic [15:0] chans;
    logic [15:0] code;
    int          len;
    bits  = $urandom_range(0, 1) ? BITS_WIDE : BITS_NARROW;
    chans = 16'($urandom_range(0, 3));
    code  = PCM_CODE;
    len   = 16;
    if ($urandom_range(0, 9) == 0)
      bits = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 19) == 0)
      chans = 16'($urandom_range(4, 65535));
    if ($urandom_range(0, 15) == 0)
      code = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 9) == 0)
      len = $urandom_range(0, 24);
    put_fmt(code, chans, $urandom, bits, len);
  endtask

  task automatic trim_file(input int keep);
    while (wav_bytes.size() > keep)
      wav_bytes.delete(wav_bytes.size() - 1);
  endtask

  task automatic send_file(input logic with_end);
    for (int i = 0; i < wav_bytes.size(); i++)
      send_byte(wav_bytes[i], i == 0, with_end && (i == wav_bytes.size() - 1));
    wav_bytes.delete();
  endtask

  initial begin
    in_valid         = 1'b0;
    in_byte_value    = 8'd0;
    in_start_of_file = 1'b0;
    in_end_of_file   = 1'b0;
    rst_n            = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    put_header(MAGIC_RIFF ^ 32'h0100_0000, MAGIC_WAVE);
    put_chunk(MAGIC_DATA, 2);
    send_file(1'b1);

    put_header(MAGIC_RIFF, MAGIC_WAVE ^ 32'h0000_0001);
    put_chunk(MAGIC_DATA, 3);
    send_file(1'b1);

    put_header(MAGIC_RIFF, MAGIC_WAVE);
    put_fmt(16'hFFFE, 16'd1, 32'd8000, BITS_WIDE, 16);
    send_file(1'b1);

    put_header(MAGIC_RIFF, MAGIC_WAVE);
    put_fmt(PCM_CODE, 16'd2, 32'd44100, 16'd24, 16);
    send_file(1'b1);

    put_header(MAGIC_RIFF, MAGIC_WAVE);
    put_chunk(MAGIC_DATA, 4);
    send_file(1'b1);

    put_header(MAGIC_RIFF, MAGIC_WAVE);
    put_fmt(PCM_CODE, 16'd1, 32'hFFFF_FFFF, BITS_NARROW, 16);
    put_word(MAGIC_DATA, 4);
    put_word(32'd5, 4);
    put_word(32'h7F80_FF00, 4);
    put_word(32'h0000_0001, 2);
    put_chunk($urandom, 3);
    put_chunk(MAGIC_DATA, 0);
    send_file(1'b1);

    // stereo 16-bit with a partial last frame, then a zero channel count
    put_header(MAGIC_RIFF, MAGIC_WAVE);
    put_fmt(PCM_CODE, 16'd2, 32'd48000, BITS_WIDE, 18);
    put_chunk(MAGIC_DATA, 9);
    put_fmt(PCM_CODE, 16'd0, 32'd8000, BITS_NARROW, 16);
    put_chunk(MAGIC_DATA, 3);
    send_file(1'b1);

    put_header(MAGIC_RIFF, MAGIC_WAVE);
    put_fmt(PCM_CODE, 16'd1, 32'd22050, BITS_NARROW, 9);
    put_chunk(MAGIC_DATA, 2);
    send_file(1'b1);

    put_word(MAGIC_RIFF, 4);
    send_file(1'b1);

    put_header(MAGIC_RIFF, MAGIC_WAVE);
    put_fmt(PCM_CODE, 16'hFFFF, 32'd11025, BITS_NARROW, 16);
    put_chunk(MAGIC_DATA, 6);
    send_file(1'b1);
    repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));

    put_header(MAGIC_RIFF, MAGIC_WAVE);
    put_fmt(PCM_CODE, 16'd1, 32'd16000, BITS_WIDE, 16);
    put_chunk(MAGIC_DATA, 100);
    trim_file(54);
    send_file(1'b1);

    // restart in the middle of a format chunk
    put_header(MAGIC_RIFF, MAGIC_WAVE);
    put_fmt(PCM_CODE, 16'd1, 32'd16000, BITS_WIDE, 16);
    trim_file(20);
    send_file(1'b0);

    put_header(MAGIC_RIFF, MAGIC_WAVE);
    put_fmt(PCM_CODE, 16'd3, 32'd96000, BITS_WIDE, 16);
    send_file(1'b1);

    while (bytes_sent < 1050) begin
      put_header(MAGIC_RIFF, MAGIC_WAVE);
      if ($urandom_range(0, 4) != 0)
        put_random_fmt();
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 5))
          0:       put_chunk($urandom, $urandom_range(0, 7));
          1:       put_random_fmt();
          default: put_chunk(MAGIC_DATA, $urandom_range(0, 40));
        endcase
      end
      if ($urandom_range(0, 7) == 0)
        wav_bytes[$urandom_range(0, wav_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0)
        trim_file($urandom_range(1, wav_bytes.size()));
      send_file($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 5))
          send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    end
    in_valid = 1'b0;

    while (awaited != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
